// ===== sv/rvft_pkg.sv =====
// Shared widths, codes and types for the VLAN filter table.
package rvft_pkg;

  localparam int VID_W    = 12;
  localparam int CNT_W    = 16;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 3;
  localparam int LIVE_W   = 8;

  localparam int TABLE_DEPTH_DEF    = 128;
  localparam int RESERVED_SLOTS_DEF = 2;

  localparam logic [LIVE_W-1:0] MAX_ENTRIES_RESET = 8'd128;
  localparam logic [CNT_W-1:0]  COUNT_FULL        = 16'hffff;

  localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNREGISTER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND       = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

  typedef struct packed {
    logic [VID_W-1:0] vlan;
    logic [CNT_W-1:0] count;
  } slot_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VID_W-1:0]  vlan_id;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_index;
    logic                table_changed;
  } rsp_t;

endpackage

// ===== sv/rvft_if.sv =====
// Request and response channel interfaces.
interface rvft_req_if;
  logic                       valid;
  logic                       ready;
  logic [rvft_pkg::KIND_W-1:0] kind;
  logic [rvft_pkg::VID_W-1:0]  vlan_id;
  logic [rvft_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, kind, vlan_id, slot_index, input ready);
  modport sink   (input valid, kind, vlan_id, slot_index, output ready);
endinterface

interface rvft_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rvft_pkg::STATUS_W-1:0] status;
  logic [rvft_pkg::SLOT_W-1:0]   result_index;
  logic                          table_changed;

  modport source (output valid, status, result_index, table_changed, input ready);
  modport sink   (input valid, status, result_index, table_changed, output ready);
endinterface

// ===== sv/rvft_slot_ram.sv =====
// Slot memory: one write port, one registered read port.
module rvft_slot_ram #(
  parameter int TABLE_DEPTH = rvft_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  rvft_pkg::slot_t     wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output rvft_pkg::slot_t     rdata
);

  rvft_pkg::slot_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rvft_scan_ctrl.sv =====
// Request sequencer: slot scan with one shared compare, live flags and live count.
module rvft_scan_ctrl #(
  parameter int TABLE_DEPTH    = rvft_pkg::TABLE_DEPTH_DEF,
  parameter int RESERVED_SLOTS = rvft_pkg::RESERVED_SLOTS_DEF,
  parameter int IDX_W          = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rvft_pkg::req_t              req,
  input  logic [rvft_pkg::LIVE_W-1:0] max_entries,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rvft_pkg::rsp_t              res,
  output logic                        mem_we,
  output logic [IDX_W-1:0]            mem_waddr,
  output rvft_pkg::slot_t             mem_wdata,
  output logic                        mem_re,
  output logic [IDX_W-1:0]            mem_raddr,
  input  rvft_pkg::slot_t             mem_rdata
);

  localparam int SW = rvft_pkg::SLOT_W;
  localparam int LW = rvft_pkg::LIVE_W;
  localparam int CW = rvft_pkg::CNT_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_UNRD     = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;

  localparam logic [IDX_W:0]   PTR_END   = (IDX_W+1)'(TABLE_DEPTH);
  localparam logic [IDX_W:0]   PTR_RES   = (IDX_W+1)'(RESERVED_SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [SW-1:0]    SIDX_RES  = SW'(RESERVED_SLOTS);
  localparam logic [SW:0]      SIDX_END  = (SW+1)'(TABLE_DEPTH);

  logic [2:0]             state, state_next;
  rvft_pkg::req_t         req_q, req_q_next;
  logic [IDX_W:0]         issue_ptr, issue_ptr_next;
  logic                   cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0]       cmp_ptr, cmp_ptr_next;
  logic                   free_found, free_found_next;
  logic [IDX_W-1:0]       free_ptr, free_ptr_next;
  logic [LW-1:0]          live_total, live_total_next;
  logic [TABLE_DEPTH-1:0] live, live_next;
  rvft_pkg::rsp_t         res_q, res_q_next;

  logic             hit;
  logic             free_now;
  logic [IDX_W-1:0] free_sel;
  logic             bad_slot;
  logic [CW-1:0]    cnt_dec;
  logic [IDX_W-1:0] sidx;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res       = res_q;

  assign sidx     = req_q.slot_index[IDX_W-1:0];
  assign hit      = cmp_vld && live[cmp_ptr] && (mem_rdata.vlan == req_q.vlan_id);
  assign free_now = free_found || !live[cmp_ptr];
  assign free_sel = free_found ? free_ptr : cmp_ptr;
  assign cnt_dec  = mem_rdata.count - CW'(1);
  assign bad_slot = (req_q.slot_index < SIDX_RES) ||
                    ({1'b0, req_q.slot_index} >= SIDX_END) || !live[sidx];

  always_comb begin
    state_next      = state;
    req_q_next      = req_q;
    issue_ptr_next  = issue_ptr;
    cmp_vld_next    = 1'b0;
    cmp_ptr_next    = cmp_ptr;
    free_found_next = free_found;
    free_ptr_next   = free_ptr;
    live_total_next = live_total;
    live_next       = live;
    res_q_next      = res_q;
    mem_we          = 1'b0;
    mem_waddr       = cmp_ptr;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = issue_ptr[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_q_next = req;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        issue_ptr_next  = '0;
        free_found_next = 1'b0;
        case (req_q.kind)
          rvft_pkg::KIND_REGISTER: begin
            issue_ptr_next = PTR_RES;
            state_next     = S_SCAN;
          end
          rvft_pkg::KIND_FIND: begin
            state_next = S_SCAN;
          end
          rvft_pkg::KIND_UNREGISTER: begin
            if (bad_slot) begin
              res_q_next = '{rvft_pkg::ST_BAD_SLOT, '0, 1'b0};
              state_next = S_RESP;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = sidx;
              state_next = S_UNRD;
            end
          end
          default: begin
            res_q_next = '{rvft_pkg::ST_NOT_FOUND, '0, 1'b0};
            state_next = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        // issue the next read while the previous slot is compared
        if (issue_ptr < PTR_END) begin
          mem_re         = 1'b1;
          issue_ptr_next = issue_ptr + 1'b1;
          cmp_vld_next   = 1'b1;
          cmp_ptr_next   = issue_ptr[IDX_W-1:0];
        end
        if (hit) begin
          cmp_vld_next = 1'b0;
          state_next   = S_RESP;
          if (req_q.kind == rvft_pkg::KIND_REGISTER &&
              mem_rdata.count == rvft_pkg::COUNT_FULL) begin
            res_q_next = '{rvft_pkg::ST_OVERFLOW, '0, 1'b0};
          end else begin
            if (req_q.kind == rvft_pkg::KIND_REGISTER) begin
              mem_we    = 1'b1;
              mem_waddr = cmp_ptr;
              mem_wdata = '{mem_rdata.vlan, mem_rdata.count + CW'(1)};
            end
            res_q_next = '{rvft_pkg::ST_OK, SW'(cmp_ptr), 1'b0};
          end
        end else if (cmp_vld) begin
          if (!free_found && !live[cmp_ptr]) begin
            free_found_next = 1'b1;
            free_ptr_next   = cmp_ptr;
          end
          if (cmp_ptr == LAST_SLOT) begin
            cmp_vld_next = 1'b0;
            state_next   = S_RESP;
            if (req_q.kind != rvft_pkg::KIND_REGISTER) begin
              res_q_next = '{rvft_pkg::ST_NOT_FOUND, '0, 1'b0};
            end else if (!free_now) begin
              res_q_next = '{rvft_pkg::ST_NO_FREE, '0, 1'b0};
            end else if (live_total >= max_entries) begin
              res_q_next = '{rvft_pkg::ST_FULL, '0, 1'b0};
            end else begin
              mem_we              = 1'b1;
              mem_waddr           = free_sel;
              mem_wdata           = '{req_q.vlan_id, CW'(1)};
              live_next[free_sel] = 1'b1;
              live_total_next     = live_total + 1'b1;
              res_q_next          = '{rvft_pkg::ST_OK, SW'(free_sel), 1'b1};
            end
          end
        end
      end
      S_UNRD: begin
        state_next = S_RESP;
        if (cnt_dec == '0) begin
          // last reference gone: drop the live flag, the entry then reads as empty
          live_next[sidx] = 1'b0;
          if (live_total != '0) begin
            live_total_next = live_total - 1'b1;
          end
          res_q_next = '{rvft_pkg::ST_OK, req_q.slot_index, 1'b1};
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = sidx;
          mem_wdata  = '{mem_rdata.vlan, cnt_dec};
          res_q_next = '{rvft_pkg::ST_OK, req_q.slot_index, 1'b0};
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
      live_total <= '0;
      live       <= '0;
    end else begin
      state      <= state_next;
      cmp_vld    <= cmp_vld_next;
      free_found <= free_found_next;
      live_total <= live_total_next;
      live       <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q     <= req_q_next;
    issue_ptr <= issue_ptr_next;
    cmp_ptr   <= cmp_ptr_next;
    free_ptr  <= free_ptr_next;
    res_q     <= res_q_next;
  end

endmodule

// ===== sv/refcounted_vlan_filter_table_top.sv =====
// Top level of the reference-counted VLAN filter table; one request is in service at a time.
// A register or find request scans the slots, register starting past the reserved ones; a live
// match stops the scan early. Unregister reads its one slot; a refused one, like an unused kind,
// answers without a memory access. The scan takes one slot per cycle through the single read
// port and the shared compare.
// Synchronous reset clears the live flags at once (no clearing pass); max_entries resets to 128.
module refcounted_vlan_filter_table_top #(
  parameter int TABLE_DEPTH    = rvft_pkg::TABLE_DEPTH_DEF,
  parameter int RESERVED_SLOTS = rvft_pkg::RESERVED_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  rvft_req_if.sink                    req,
  rvft_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [rvft_pkg::LIVE_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // configuration: live entry limit
  logic [rvft_pkg::LIVE_W-1:0] max_entries;

  // request bundle handed to the sequencer
  rvft_pkg::req_t   req_bus;

  // finished result from the sequencer
  logic             res_valid;
  logic             res_ready;
  rvft_pkg::rsp_t   res_bus;

  // output register, parts the sequencer from the response sink
  logic             out_valid;
  rvft_pkg::rsp_t   out_q;

  // slot memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rvft_pkg::slot_t  mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  rvft_pkg::slot_t  mem_rdata;

  assign req_bus = '{req.kind, req.vlan_id, req.slot_index};

  // write the limit whenever the enable is high
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= rvft_pkg::MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      max_entries <= cfg_wdata;
    end
  end

  // take a finished result when the output register is empty or being drained
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload until its transfer
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res_bus;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_q.status;
  assign rsp.result_index  = out_q.result_index;
  assign rsp.table_changed = out_q.table_changed;

  rvft_scan_ctrl #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .RESERVED_SLOTS (RESERVED_SLOTS),
    .IDX_W          (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .req         (req_bus),
    .max_entries (max_entries),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res_bus),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  rvft_slot_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the reference-counted VLAN filter table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rvft_pkg::*;

  localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
  localparam int RESERVED_SLOTS = RESERVED_SLOTS_DEF;

  // Kind code the block does not define; it must answer not found.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Receiver hold-off for the back-pressure test, and the run's cycle budget.
  localparam int HOLD_CYCLES    = 3000;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int PRINTED_ERRORS = 40;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [LIVE_W-1:0] cfg_wdata;

  rvft_req_if req_if ();
  rvft_rsp_if rsp_if ();

  refcounted_vlan_filter_table_top #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .RESERVED_SLOTS (RESERVED_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the slot table, the live total and the maximum.
  logic [VID_W-1:0]  tbl_vlan  [TABLE_DEPTH];
  logic [CNT_W-1:0]  tbl_count [TABLE_DEPTH];
  logic [LIVE_W-1:0] live_entries;
  logic [LIVE_W-1:0] entry_limit;

  // Responses still owed by the block, oldest first.
  rsp_t expected_rsp [$];

  // IDs the random requests draw from, so that matches and a full table occur.
  logic [VID_W-1:0] vid_pool [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int requests_sent;
  int status_seen [8];
  int cycle_count;
  logic hold_go;
  logic hold_rsp;

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abandon the run if it overstays its budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_rsp.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Print one line per mismatch (up to a cap) and count it.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINTED_ERRORS)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one request to the shadow table and return the response it owes.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    int free_slot;
    bit matched;
    res = '0;
    res.status = ST_OK;
    free_slot = -1;
    matched = 1'b0;
    case (r.kind)
      KIND_REGISTER: begin
        // Scan past the reserved slots; remember the first hole, stop at a live match.
        for (int i = RESERVED_SLOTS; i < TABLE_DEPTH && !matched; i++) begin
          if (tbl_count[i] == '0) begin
            if (free_slot < 0) free_slot = i;
          end else if (tbl_vlan[i] == r.vlan_id) begin
            matched = 1'b1;
            if (tbl_count[i] == COUNT_FULL) begin
              res.status = ST_OVERFLOW;
            end else begin
              tbl_count[i] = tbl_count[i] + 1'b1;
              res.result_index = SLOT_W'(i);
            end
          end
        end
        if (!matched) begin
          if (free_slot < 0) begin
            res.status = ST_NO_FREE;
          end else if (live_entries >= entry_limit) begin
            res.status = ST_FULL;
          end else begin
            tbl_count[free_slot] = CNT_W'(1);
            tbl_vlan[free_slot]  = r.vlan_id;
            live_entries         = live_entries + 1'b1;
            res.result_index     = SLOT_W'(free_slot);
            res.table_changed    = 1'b1;
          end
        end
      end
      KIND_UNREGISTER: begin
        if (int'(r.slot_index) < RESERVED_SLOTS || int'(r.slot_index) >= TABLE_DEPTH ||
            tbl_count[r.slot_index] == '0) begin
          res.status = ST_BAD_SLOT;
        end else begin
          tbl_count[r.slot_index] = tbl_count[r.slot_index] - 1'b1;
          res.result_index = r.slot_index;
          if (tbl_count[r.slot_index] == '0) begin
            tbl_vlan[r.slot_index] = '0;
            if (live_entries != '0) live_entries = live_entries - 1'b1;
            res.table_changed = 1'b1;
          end
        end
      end
      KIND_FIND: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < TABLE_DEPTH && !matched; i++) begin
          if (tbl_count[i] != '0 && tbl_vlan[i] == r.vlan_id) begin
            matched = 1'b1;
            res.status = ST_OK;
            res.result_index = SLOT_W'(i);
          end
        end
      end
      default: res.status = ST_NOT_FOUND;
    endcase
    return res;
  endfunction

  // Pick one live slot at random; return 0 when the table is empty.
  function automatic bit pick_live_slot(output logic [SLOT_W-1:0] slot);
    int live_slots [$];
    slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_count[i] != '0) live_slots.push_back(i);
    if (live_slots.size() == 0) return 1'b0;
    slot = SLOT_W'(live_slots[$urandom_range(live_slots.size() - 1)]);
    return 1'b1;
  endfunction

  function automatic logic [VID_W-1:0] pool_vid();
    if ($urandom_range(99) < 85) return vid_pool[$urandom_range(vid_pool.size() - 1)];
    return VID_W'($urandom);
  endfunction

  // Build a request: register, unregister and find by weight, the rest noise.
  function automatic req_t random_request(input int reg_w, input int unreg_w, input int find_w);
    req_t r;
    int roll;
    logic [SLOT_W-1:0] s;
    r.kind       = KIND_W'($urandom_range(3));
    r.vlan_id    = VID_W'($urandom);
    r.slot_index = SLOT_W'($urandom);
    roll = $urandom_range(99);
    if (roll < reg_w) begin
      r.kind = KIND_REGISTER;
      r.vlan_id = pool_vid();
    end else if (roll < reg_w + unreg_w) begin
      r.kind = KIND_UNREGISTER;
      if ($urandom_range(99) < 85 && pick_live_slot(s)) r.slot_index = s;
    end else if (roll < reg_w + unreg_w + find_w) begin
      r.kind = KIND_FIND;
      if ($urandom_range(99) < 70 && pick_live_slot(s)) r.vlan_id = tbl_vlan[s];
      else r.vlan_id = pool_vid();
    end
    return r;
  endfunction

  // Offer one request and hold it until the transfer. Valid stays high on return,
  // so the next call either replaces the payload or drops valid for a gap.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= r.kind;
    req_if.vlan_id    <= r.vlan_id;
    req_if.slot_index <= r.slot_index;
    do @(posedge clk); while (!req_if.ready);
    expected_rsp.push_back(apply_request(r));
    requests_sent++;
  endtask

  // Drop valid and wait until every owed response has been taken.
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write the maximum only while the block is idle.
  task automatic write_max_entries(input logic [LIVE_W-1:0] value);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    entry_limit = value;
  endtask

  // Take responses when ready and valid meet, compare each with the oldest
  // expectation, then choose the next ready.
  initial begin : response_checker
    rsp_t want;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        status_seen[rsp_if.status]++;
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("response with none outstanding: status %0d index %0d",
                                    rsp_if.status, rsp_if.result_index));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_if.status, want.status));
          if (rsp_if.result_index !== want.result_index)
            report_mismatch($sformatf("result_index %0d, expected %0d",
                                      rsp_if.result_index, want.result_index));
          if (rsp_if.table_changed !== want.table_changed)
            report_mismatch($sformatf("table_changed %0b, expected %0b",
                                      rsp_if.table_changed, want.table_changed));
        end
      end
      rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold the receiver off for a long stretch once asked, counting the cycles here.
  initial begin : receiver_hold
    hold_rsp <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
      end
    end
  end

  // Extremes of every field, each kind and the corner cases of the scan.
  task automatic test_directed_cases();
    send_request(req_t'{KIND_FIND,       12'h000, 7'd0});   // empty table
    send_request(req_t'{KIND_FIND,       12'hfff, 7'd127});
    send_request(req_t'{KIND_UNREGISTER, 12'hfff, 7'd0});   // reserved slots
    send_request(req_t'{KIND_UNREGISTER, 12'h000, 7'd1});
    send_request(req_t'{KIND_UNREGISTER, 12'hfff, 7'd127}); // empty, last slot
    send_request(req_t'{KIND_UNREGISTER, 12'h000, 7'd2});   // empty, first usable
    send_request(req_t'{KIND_REGISTER,   12'hfff, 7'd127}); // new ID into first usable slot
    send_request(req_t'{KIND_REGISTER,   12'h000, 7'd0});
    send_request(req_t'{KIND_REGISTER,   12'hfff, 7'd0});   // second reference
    send_request(req_t'{KIND_FIND,       12'hfff, 7'd0});
    send_request(req_t'{KIND_FIND,       12'h000, 7'd0});
    send_request(req_t'{KIND_UNREGISTER, 12'h000, 7'd2});   // references remain
    send_request(req_t'{KIND_UNREGISTER, 12'h000, 7'd2});   // last reference clears
    // A hole now precedes the live match: the scan must pass over it.
    send_request(req_t'{KIND_REGISTER,   12'h000, 7'd127});
    send_request(req_t'{KIND_REGISTER,   12'h5a5, 7'd0});   // refill the hole
    send_request(req_t'{KIND_FIND,       12'h5a5, 7'd0});
    send_request(req_t'{KIND_UNUSED,     12'habc, 7'd85});
    send_request(req_t'{KIND_UNREGISTER, 12'hfff, 7'd3});
    // Lower the maximum below the live total: new IDs blocked, matches allowed.
    write_max_entries(LIVE_W'(1));
    send_request(req_t'{KIND_REGISTER,   12'h123, 7'd0});
    send_request(req_t'{KIND_REGISTER,   12'h000, 7'd0});
    send_request(req_t'{KIND_FIND,       12'h123, 7'd0});
    wait_for_drain();
  endtask

  // Register-heavy traffic at the widest maximum until the slots run out.
  task automatic test_fill_to_capacity();
    write_max_entries(MAX_ENTRIES_RESET);
    repeat (650) send_request(random_request(70, 10, 15));
    wait_for_drain();
  endtask

  // Smallest maximum against a well-filled table, then drain it.
  task automatic test_lowered_maximum();
    write_max_entries(LIVE_W'(1));
    repeat (300) send_request(random_request(35, 45, 15));
    wait_for_drain();
  endtask

  // Starve the receiver while requests keep coming, so the input stalls.
  task automatic test_response_backpressure();
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (40) send_request(random_request(40, 30, 25));
    wait_for_drain();
  endtask

  // Step through a spread of maxima, extremes included; drop idling halfway.
  task automatic test_maximum_sweep();
    int maxima [7];
    maxima = '{64, 127, 2, 126, 128, 1, 0};
    maxima[6] = $urandom_range(1, 128);
    for (int k = 0; k < 7; k++) begin
      if (k == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_max_entries(LIVE_W'(maxima[k]));
      repeat (120) send_request(random_request(40, 35, 20));
    end
    wait_for_drain();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= '0;
    req_if.vlan_id    <= '0;
    req_if.slot_index <= '0;
    hold_go  <= 1'b0;
    error_count   = 0;
    requests_sent = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_vlan[i]  = '0;
      tbl_count[i] = '0;
    end
    live_entries = '0;
    entry_limit  = MAX_ENTRIES_RESET;

    // Pool holds both extreme IDs plus enough others to overflow the table.
    vid_pool.push_back('0);
    vid_pool.push_back('1);
    repeat (158) vid_pool.push_back(VID_W'($urandom));

    // Sender rarely idles, receiver mostly stalls.
    send_idle_pct = 17;
    recv_idle_pct = 69;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_fill_to_capacity();

    // Swap: sender mostly idles, receiver rarely stalls.
    send_idle_pct = 69;
    recv_idle_pct = 17;
    test_lowered_maximum();
    test_response_backpressure();
    test_maximum_sweep();

    // Allow one full scan for any stray response to show up.
    wait_for_drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("Ran %0d requests over maxima 1 to 128 with idling on both sides and a long stall.",
             requests_sent);
    $display("Statuses: ok %0d, no free %0d, full %0d, not found %0d, bad slot %0d, overflow %0d",
             status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND], status_seen[ST_BAD_SLOT], status_seen[ST_OVERFLOW]);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d responses never arrived", error_count, expected_rsp.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rvft_pkg.sv
sv/rvft_if.sv
sv/rvft_slot_ram.sv
sv/rvft_scan_ctrl.sv
sv/refcounted_vlan_filter_table_top.sv
tb/testbench.sv
